@@ rtl/rc4_pkg.sv @@
package rc4_pkg;

  // Key store depth and the width of the key byte counter (holds 0..KEY_MAX)
  localparam int unsigned KEY_MAX = 256;
  localparam int unsigned KIDX_W  = $clog2(KEY_MAX);
  localparam int unsigned KCNT_W  = $clog2(KEY_MAX + 1);

  // Input item kinds, carried on in_tuser
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic key_acc;      // store key byte, bump count
    logic sched_start;  // last key byte: latch length, clear indices
    logic init_wr;      // write S[n] = n
    logic k_rd;         // issue read of S[n] and K[n mod len]
    logic step2;        // update j, issue read of S[j]
    logic k_mode;       // add key byte into j
    logic step3;        // write S[j] = S[i], issue read of S[t]
    logic k_step4;      // write S[n] = old S[j], advance n and key index
    logic d_acc;        // accept keyed data byte, issue read of S[i+1]
    logic d_step4;      // write S[i] = old S[j], form keystream result
    logic sched_done;   // mark keyed, clear indices
    logic pass;         // result is the input byte unchanged
    logic res_cap;      // park result while output is full
    logic out_load;     // load output register
    logic out_from_res; // output register takes the parked result
  } cmd_t;

  typedef struct packed {
    logic keyed;
    logic n_last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       unkeyed;
  } res_t;

endpackage

@@ rtl/rc4_stream_cipher.sv @@
// RC4 stream cipher, byte serial.
// Input channel in_*: in_tuser selects the item kind (0 key byte, 1 data
// byte), in_tdata carries the byte, in_tlast ends a key or a message.
// Key bytes are stored one per cycle and produce no result; the last key
// byte starts the key schedule, which keeps in_tready low while it loads
// the identity table and then runs the schedule steps on the permutation
// memory, which has one read and one write port.
// Each data byte gives one result on out_*: out_tdata is the byte XOR the
// keystream, out_tlast copies in_tlast, out_tuser flags an unkeyed block
// (byte passed unchanged). A keyed data byte takes three dependent reads of
// the permutation memory and the swap write-back; its result is loaded into
// the output register at the write-back step. An unkeyed byte is loaded
// as it is accepted. The i and j indices restart after each last data
// byte; the table carries over to the next message.
// Reset clears the key count, indices and keyed flag; the block is then
// unkeyed. When the receiver stalls, one result waits in the output
// register and one more is parked; after that the block holds in_tready low.
module rc4_stream_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  input  logic       in_tuser,   // [0] opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] unkeyed
);
  import rc4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_opcode(in_tuser),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rc4_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_unkeyed(out_tuser)
  );

endmodule

@@ rtl/rc4_ctrl.sv @@
module rc4_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_opcode,
  input  logic          in_last,
  output logic          in_ready,
  output rc4_pkg::cmd_t cmd,
  input  rc4_pkg::sts_t sts
);
  import rc4_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_K1   = 4'd2;
  localparam logic [3:0] S_K2   = 4'd3;
  localparam logic [3:0] S_K3   = 4'd4;
  localparam logic [3:0] S_K4   = 4'd5;
  localparam logic [3:0] S_D2   = 4'd6;
  localparam logic [3:0] S_D3   = 4'd7;
  localparam logic [3:0] S_D4   = 4'd8;
  localparam logic [3:0] S_PUSH = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_opcode == OP_KEY) begin
            cmd.key_acc = 1'b1;
            if (in_last) begin
              cmd.sched_start = 1'b1;
              state_nxt       = S_INIT;
            end
          end else if (!sts.keyed) begin
            cmd.pass = 1'b1;
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
            end else begin
              cmd.res_cap = 1'b1;
              state_nxt   = S_PUSH;
            end
          end else begin
            cmd.d_acc = 1'b1;
            state_nxt = S_D2;
          end
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.n_last) begin
          state_nxt = S_K1;
        end
      end
      S_K1: begin
        cmd.k_rd  = 1'b1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.step2  = 1'b1;
        cmd.k_mode = 1'b1;
        state_nxt  = S_K3;
      end
      S_K3: begin
        cmd.step3 = 1'b1;
        state_nxt = S_K4;
      end
      S_K4: begin
        cmd.k_step4 = 1'b1;
        if (sts.n_last) begin
          cmd.sched_done = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_K1;
        end
      end
      S_D2: begin
        cmd.step2 = 1'b1;
        state_nxt = S_D3;
      end
      S_D3: begin
        cmd.step3 = 1'b1;
        state_nxt = S_D4;
      end
      S_D4: begin
        cmd.d_step4 = 1'b1;
        state_nxt   = S_IDLE;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
        end else begin
          cmd.res_cap = 1'b1;
          state_nxt   = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.out_from_res = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Schedule starts only from an accepted last key byte
  a_init_from_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT && $past(state_r) != S_INIT)
      |-> $past(acc && in_opcode == OP_KEY && in_last))
    else $error("key schedule entered without last key byte");

  // Keystream write-back follows the S[j] step
  a_d4_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D4) |-> ($past(state_r) == S_D3))
    else $error("data step order broken");

  // A schedule step starts after the table load or after the previous step
  a_k1_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_K1) |-> ($past(state_r) == S_INIT || $past(state_r) == S_K4))
    else $error("schedule step entered out of order");

endmodule

@@ rtl/rc4_dpath.sv @@
module rc4_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  rc4_pkg::cmd_t cmd,
  output rc4_pkg::sts_t sts,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_unkeyed
);
  import rc4_pkg::*;

  logic [7:0]        perm_mem [256];
  logic [7:0]        key_mem  [KEY_MAX];

  logic [7:0]        perm_rd_r;
  logic [7:0]        key_rd_r;
  logic [7:0]        n_r;
  logic [KIDX_W-1:0] kidx_r;
  logic [KCNT_W-1:0] len_r;
  logic [KCNT_W-1:0] key_len_r;
  logic [7:0]        i_r;
  logic [7:0]        j_r;
  logic [7:0]        si_r;
  logic [7:0]        sj_r;
  logic [7:0]        t_r;
  logic [7:0]        byte_r;
  logic              last_r;
  logic              keyed_r;
  logic              out_valid_r;
  res_t              res_r;
  res_t              out_r;

  logic [7:0]        perm_rd_addr;
  logic              perm_we;
  logic [7:0]        perm_wa;
  logic [7:0]        perm_wd;
  logic [7:0]        j_sum;
  logic [7:0]        t_sum;
  logic [7:0]        ks;
  logic              key_room;
  logic              kidx_wrap;
  res_t              live;

  assign key_room  = (key_len_r != KCNT_W'(KEY_MAX));
  assign kidx_wrap = ((KCNT_W'(kidx_r) + KCNT_W'(1)) >= len_r);
  assign j_sum     = j_r + perm_rd_r + (cmd.k_mode ? key_rd_r : 8'h00);
  assign t_sum     = si_r + perm_rd_r;

  // S[t] was read before S[i] was rewritten: bypass the swapped entries
  assign ks = (t_r == i_r) ? sj_r :
              (t_r == j_r) ? si_r : perm_rd_r;

  always_comb begin
    if (cmd.pass) begin
      live = '{data: in_byte, last: in_last, unkeyed: 1'b1};
    end else begin
      live = '{data: byte_r ^ ks, last: last_r, unkeyed: 1'b0};
    end
  end

  always_comb begin
    perm_rd_addr = n_r;
    if (cmd.d_acc) begin
      perm_rd_addr = i_r + 8'd1;
    end else if (cmd.step2) begin
      perm_rd_addr = j_sum;
    end else if (cmd.step3) begin
      perm_rd_addr = t_sum;
    end
  end

  always_comb begin
    perm_we = 1'b0;
    perm_wa = n_r;
    perm_wd = n_r;
    if (cmd.init_wr) begin
      perm_we = 1'b1;
    end else if (cmd.step3) begin
      perm_we = 1'b1;
      perm_wa = j_r;
      perm_wd = si_r;
    end else if (cmd.k_step4) begin
      perm_we = 1'b1;
      perm_wd = sj_r;
    end else if (cmd.d_step4) begin
      perm_we = 1'b1;
      perm_wa = i_r;
      perm_wd = sj_r;
    end
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    perm_rd_r <= perm_mem[perm_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_acc && key_room) begin
      key_mem[key_len_r[KIDX_W-1:0]] <= in_byte;
    end
    if (cmd.k_rd) begin
      key_rd_r <= key_mem[kidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r   <= '0;
      len_r       <= KCNT_W'(1);
      n_r         <= '0;
      kidx_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sched_start) begin
        len_r     <= key_room ? key_len_r + KCNT_W'(1) : key_len_r;
        key_len_r <= '0;
        n_r       <= '0;
        kidx_r    <= '0;
        i_r       <= '0;
        j_r       <= '0;
      end else if (cmd.key_acc && key_room) begin
        key_len_r <= key_len_r + KCNT_W'(1);
      end
      if (cmd.init_wr || cmd.k_step4) begin
        n_r <= n_r + 8'd1;
      end
      if (cmd.k_step4) begin
        kidx_r <= kidx_wrap ? '0 : kidx_r + KIDX_W'(1);
      end
      if (cmd.step2) begin
        j_r <= j_sum;
      end
      if (cmd.d_acc) begin
        i_r <= i_r + 8'd1;
      end
      // End of message or end of schedule: restart the indices
      if (cmd.sched_done || (cmd.d_step4 && last_r)) begin
        i_r <= '0;
        j_r <= '0;
      end
      if (cmd.sched_done) begin
        keyed_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step2) begin
      si_r <= perm_rd_r;
    end
    if (cmd.step3) begin
      sj_r <= perm_rd_r;
      t_r  <= t_sum;
    end
    if (cmd.d_acc) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (cmd.res_cap) begin
      res_r <= live;
    end
    if (cmd.out_load) begin
      out_r <= cmd.out_from_res ? res_r : live;
    end
  end

  assign sts.keyed    = keyed_r;
  assign sts.n_last   = (n_r == 8'hFF);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_byte    = out_r.data;
  assign out_last    = out_r.last;
  assign out_unkeyed = out_r.unkeyed;

  a_key_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    key_len_r <= KCNT_W'(KEY_MAX))
    else $error("key count past key store depth");

  a_sched_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sched_done |=> (keyed_r && i_r == 8'd0 && j_r == 8'd0))
    else $error("indices not cleared after key schedule");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output overwritten before it was taken");

endmodule

@@ sim/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rc4_pkg::*;

  localparam int RANDOM_ITEMS = 1360;
  localparam int CALM_AFTER   = 1150;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;
  logic       in_tuser = OP_KEY;  // [0] opcode
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;
  logic       out_tuser;          // [0] unkeyed

  rc4_stream_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cipher state mirrored for prediction
  logic [7:0] s_box [256];
  logic [7:0] key_bytes [KEY_MAX];
  int         key_count = 0;
  logic [7:0] idx_i = 8'h00;
  logic [7:0] idx_j = 8'h00;
  bit         have_key = 1'b0;

  res_t cipher_fifo [$];
  int   fail_count = 0;
  bit   calm = 1'b0;

  function automatic void schedule_key(int len);
    logic [7:0] j;
    logic [7:0] t;
    j = 8'h00;
    for (int n = 0; n < 256; n++) s_box[n] = 8'(n);
    for (int n = 0; n < 256; n++) begin
      j = j + s_box[n] + key_bytes[n % len];
      t = s_box[n];
      s_box[n] = s_box[j];
      s_box[j] = t;
    end
  endfunction

  // Advance the mirrored state by one item; returns 1 when a result byte is due
  function automatic bit cipher_step(logic op, logic [7:0] b, logic lst, output res_t r);
    logic [7:0] t;
    r = '0;
    if (op == OP_KEY) begin
      if (key_count < KEY_MAX) begin
        key_bytes[key_count] = b;
        key_count++;
      end
      if (lst) begin
        schedule_key(key_count);
        key_count = 0;
        idx_i = 8'h00;
        idx_j = 8'h00;
        have_key = 1'b1;
      end
      return 1'b0;
    end
    r.last = lst;
    if (!have_key) begin
      r.data = b;
      r.unkeyed = 1'b1;
      return 1'b1;
    end
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + s_box[idx_i];
    t = s_box[idx_i];
    s_box[idx_i] = s_box[idx_j];
    s_box[idx_j] = t;
    t = s_box[idx_i] + s_box[idx_j];
    r.data = b ^ s_box[t];
    r.unkeyed = 1'b0;
    if (lst) begin
      idx_i = 8'h00;
      idx_j = 8'h00;
    end
    return 1'b1;
  endfunction

  // Drive one item, wait for the handshake, then queue its result
  task automatic send_item(logic op, logic [7:0] b, logic lst, bit typed, res_t typed_res);
    res_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (cipher_step(op, b, lst, r)) cipher_fifo.push_back(typed ? typed_res : r);
  endtask

  // Receiver: stall in random bursts, never once the run turns calm
  int stall_left = 0;
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_fifo.size() == 0) begin
        $error("unexpected result byte %02h", out_tdata);
        fail_count++;
      end else begin
        want = cipher_fifo.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_tdata: expected %02h, got %02h", want.data, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("out_tlast: expected %0b, got %0b", want.last, out_tlast);
          fail_count++;
        end
        if (out_tuser !== want.unkeyed) begin
          $error("out_tuser: expected %0b, got %0b", want.unkeyed, out_tuser);
          fail_count++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // rep > 1 sends that many random bytes, last only on the final one;
  // typed rows carry their expected result
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       lst;
    logic [9:0] rep;
    logic       typed;
    logic [7:0] x_data;
    logic       x_unk;
  } stim_row_t;

  localparam int NUM_ROWS = 25;
  stim_row_t dir_rows [NUM_ROWS];

  initial begin
    int   random_sent;
    int   kind;
    int   len;
    res_t typed_res;
    logic [7:0] b;

    dir_rows = '{
      // data before any key passes unchanged
      '{OP_DATA, 8'h00, 1'b0, 10'd1, 1'b1, 8'h00, 1'b1},
      '{OP_DATA, 8'hFF, 1'b1, 10'd1, 1'b1, 8'hFF, 1'b1},
      // key "Key", message "Plaintext"
      '{OP_KEY,  8'h4B, 1'b0, 10'd1, 1'b0, 8'h00, 1'b0},
      '{OP_KEY,  8'h65, 1'b0, 10'd1, 1'b0, 8'h00, 1'b0},
      '{OP_KEY,  8'h79, 1'b1, 10'd1, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'h50, 1'b0, 10'd1, 1'b1, 8'hBB, 1'b0},
      '{OP_DATA, 8'h6C, 1'b0, 10'd1, 1'b1, 8'hF3, 1'b0},
      '{OP_DATA, 8'h61, 1'b0, 10'd1, 1'b1, 8'h16, 1'b0},
      '{OP_DATA, 8'h69, 1'b0, 10'd1, 1'b1, 8'hE8, 1'b0},
      '{OP_DATA, 8'h6E, 1'b0, 10'd1, 1'b1, 8'hD9, 1'b0},
      '{OP_DATA, 8'h74, 1'b0, 10'd1, 1'b1, 8'h40, 1'b0},
      '{OP_DATA, 8'h65, 1'b0, 10'd1, 1'b1, 8'hAF, 1'b0},
      '{OP_DATA, 8'h78, 1'b0, 10'd1, 1'b1, 8'h0A, 1'b0},
      '{OP_DATA, 8'h74, 1'b1, 10'd1, 1'b1, 8'hD3, 1'b0},
      // second message runs on the carried-over table
      '{OP_DATA, 8'h00, 1'b1, 10'd3, 1'b0, 8'h00, 1'b0},
      // rekey while keyed, with data slipped in mid load
      '{OP_KEY,  8'h00, 1'b0, 10'd1, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'hA5, 1'b0, 10'd1, 1'b0, 8'h00, 1'b0},
      '{OP_KEY,  8'hFF, 1'b1, 10'd1, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'h00, 1'b1, 10'd1, 1'b0, 8'h00, 1'b0},
      // one-byte key
      '{OP_KEY,  8'h00, 1'b1, 10'd1, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'hFF, 1'b1, 10'd1, 1'b0, 8'h00, 1'b0},
      // full-depth key, then two past it
      '{OP_KEY,  8'h00, 1'b1, 10'd256, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'h00, 1'b1, 10'd2, 1'b0, 8'h00, 1'b0},
      '{OP_KEY,  8'h00, 1'b1, 10'd258, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'h00, 1'b1, 10'd4, 1'b0, 8'h00, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      typed_res.data    = dir_rows[r].x_data;
      typed_res.last    = dir_rows[r].lst;
      typed_res.unkeyed = dir_rows[r].x_unk;
      for (int k = 0; k < int'(dir_rows[r].rep); k++) begin
        b = (dir_rows[r].rep == 10'd1) ? dir_rows[r].data : 8'($urandom_range(0, 255));
        send_item(dir_rows[r].op, b,
                  dir_rows[r].lst && (k == int'(dir_rows[r].rep) - 1),
                  dir_rows[r].typed, typed_res);
      end
    end

    // Random part: mostly keys and messages, some loose items
    random_sent = 0;
    typed_res = '0;
    while (random_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 260) : $urandom_range(1, 16);
        for (int k = 0; k < len; k++)
          send_item(OP_KEY, 8'($urandom_range(0, 255)), k == len - 1, 1'b0, typed_res);
      end else if (kind < 93) begin
        len = $urandom_range(1, 40);
        for (int k = 0; k < len; k++)
          send_item(OP_DATA, 8'($urandom_range(0, 255)), k == len - 1, 1'b0, typed_res);
      end else begin
        // stray item: data without last, or a key byte that opens a load
        len = 1;
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0, typed_res);
      end
      random_sent += len;
      if (random_sent > CALM_AFTER) calm = 1'b1;
    end

    in_tvalid <= 1'b0;
    while (cipher_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
